@@ rtl/meadisp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI actuator dispatch package
// Shared types and codes for the dispatch pipeline and its port checker.
// ----------------------------------------------------------------------------
package meadisp_pkg;

  // Result action codes.
  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_FIRE    = 4'd1,
    ACT_RELEASE = 4'd2,
    ACT_MENU    = 4'd3,
    ACT_PREV    = 4'd4,
    ACT_NEXT    = 4'd5,
    ACT_DEC     = 4'd6,
    ACT_INC     = 4'd7,
    ACT_STEPPER = 4'd8
  } act_t;

  // Event kind codes carried on in_tuser.
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_CTRL_CHG = 2'd2;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [1:0] REG_LISTEN_CH = 2'd0;
  localparam logic [1:0] REG_VEL_FLOOR = 2'd1;
  localparam logic [1:0] REG_VEL_CEIL  = 2'd2;
  localparam logic [1:0] REG_VEL_KNEE  = 2'd3;

  localparam logic [4:0] LISTEN_CH_RESET = 5'd1;
  localparam logic [4:0] LISTEN_CH_MAX   = 5'd16;
  localparam logic [6:0] VEL_FLOOR_RESET = 7'd0;
  localparam logic [6:0] VEL_CEIL_RESET  = 7'd127;
  localparam logic [6:0] VEL_KNEE_RESET  = 7'd64;

  localparam logic [6:0] STEPPER_CC      = 7'd22;
  localparam logic [3:0] FIRE_BAND       = 4'd6;   // octave 4
  localparam logic [3:0] MENU_BAND       = 4'd3;   // octave 1
  localparam logic [3:0] MAX_SOL_PITCH   = 4'd7;

  // Divide by twelve: key * 43 >> 9 is exact for keys 0..127.
  localparam logic [5:0] DIV12_MUL       = 6'd43;
  localparam int         DIV12_SHIFT     = 9;
  localparam logic [3:0] PITCHES         = 4'd12;

  // Divide by 63: n * 16645 >> 20 is exact for n up to 8128.
  localparam logic [14:0] DIV63_MUL      = 15'd16645;
  localparam int          DIV63_SHIFT    = 20;

  // Stage 1: decoded event and operands of the velocity curve.
  typedef struct packed {
    act_t             act;
    logic [3:0]       sol;
    logic             fire;
    logic [6:0]       raw_drive;   // controller value for stepper, else 0
    logic [5:0]       xoff;
    logic signed [8:0] slope;
    logic [6:0]       base;
  } s1_t;

  // Stage 2: product of the curve.
  typedef struct packed {
    act_t        act;
    logic [3:0]  sol;
    logic        fire;
    logic [6:0]  raw_drive;
    logic        neg;
    logic [13:0] mag;
    logic [6:0]  base;
  } s2_t;

  // Stage 3: quotient of the curve.
  typedef struct packed {
    act_t        act;
    logic [3:0]  sol;
    logic        fire;
    logic [6:0]  raw_drive;
    logic        neg;
    logic [7:0]  quo;
    logic [6:0]  base;
  } s3_t;

endpackage

@@ rtl/midi_event_actuator_dispatch_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event actuator dispatch
// Turns decoded MIDI events into solenoid, menu and stepper actions.
// ----------------------------------------------------------------------------
// The block takes one decoded MIDI event per request and returns exactly one
// action per event, in order. It accepts a new event in every clock cycle
// as long as out_tready is high or some stage is still empty. Each event
// passes through four register stages, the first of which loads at the
// edge that accepts it: event decode, the velocity curve multiply, the
// reciprocal multiply that divides by 63, and the final add of the base
// into the output register. When out_tready is low the stages fill up
// behind the output register and in_tready drops only once every stage holds
// an event. Events on a channel other than the listening channel, unknown
// event kinds, and notes or controllers without a mapping all give action
// "none" with zero solenoid index and drive. The velocity of a fired solenoid
// follows a two-segment curve set by the floor, knee and ceiling registers;
// with the knee at zero the low segment can reach -1, which the signed drive
// field carries. Configuration registers sit on the APB-style port at byte
// addresses 0 (listening channel, values above 16 saturate to 16), 4 (floor),
// 8 (ceiling) and 12 (knee); they must be written only while no event is in
// flight.
// ----------------------------------------------------------------------------
module midi_event_actuator_dispatch_top
  import meadisp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // event_channel[4:0], key_number[11:5],
                                  // event_value[18:12], zero pad[23:19]
  input  logic [1:0]  in_tuser,   // operation[1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // solenoid_index[3:0], drive_amount[11:4],
                                  // zero pad[15:12]
  output logic [3:0]  out_tuser,  // action[3:0]

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] listen_ch_r;
  logic [6:0] vel_floor_r;
  logic [6:0] vel_ceil_r;
  logic [6:0] vel_knee_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic [4:0] wr_ch;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];
  // A channel number above 16 saturates to 16.
  assign wr_ch      = (cfg_pwdata[4:0] > LISTEN_CH_MAX) ? LISTEN_CH_MAX : cfg_pwdata[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_ch_r <= LISTEN_CH_RESET;
      vel_floor_r <= VEL_FLOOR_RESET;
      vel_ceil_r  <= VEL_CEIL_RESET;
      vel_knee_r  <= VEL_KNEE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LISTEN_CH: listen_ch_r <= wr_ch;
        REG_VEL_FLOOR: vel_floor_r <= cfg_pwdata[6:0];
        REG_VEL_CEIL:  vel_ceil_r  <= cfg_pwdata[6:0];
        REG_VEL_KNEE:  vel_knee_r  <= cfg_pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_LISTEN_CH: cfg_prdata = {27'd0, listen_ch_r};
      REG_VEL_FLOOR: cfg_prdata = {25'd0, vel_floor_r};
      REG_VEL_CEIL:  cfg_prdata = {25'd0, vel_ceil_r};
      REG_VEL_KNEE:  cfg_prdata = {25'd0, vel_knee_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads whenever it is empty or the stage
  // after it loads in the same cycle, so a stall backs up without loss.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4       = !v4_r || out_tready;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_tvalid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode the event and pick the curve segment.
  // --------------------------------------------------------------------------
  logic [1:0]  ev_op;
  logic [4:0]  ev_ch;
  logic [6:0]  ev_key;
  logic [6:0]  ev_val;
  logic [12:0] key_scaled;
  logic [3:0]  band;
  logic [6:0]  band_base;
  logic [3:0]  pitch;
  s1_t         s1_nxt, s1_r;

  assign ev_op  = in_tuser;
  assign ev_ch  = in_tdata[4:0];
  assign ev_key = in_tdata[11:5];
  assign ev_val = in_tdata[18:12];

  assign key_scaled = {6'd0, ev_key} * {7'd0, DIV12_MUL};
  assign band       = key_scaled[12:DIV12_SHIFT];
  assign band_base  = {3'd0, band} * {3'd0, PITCHES};
  assign pitch      = 4'(ev_key - band_base);

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.act       = ACT_NONE;
    // Both segments use the low six bits of the raw velocity as offset.
    s1_nxt.xoff      = ev_val[5:0];
    if (ev_val[6]) begin
      s1_nxt.slope = $signed({2'b00, vel_ceil_r}) - $signed({2'b00, vel_knee_r});
      s1_nxt.base  = vel_knee_r;
    end else begin
      s1_nxt.slope = $signed({2'b00, vel_knee_r}) - 9'sd1 - $signed({2'b00, vel_floor_r});
      s1_nxt.base  = vel_floor_r;
    end
    if (ev_ch == listen_ch_r) begin
      unique case (ev_op)
        OP_NOTE_ON: begin
          if (band == FIRE_BAND && pitch <= MAX_SOL_PITCH) begin
            s1_nxt.act  = ACT_FIRE;
            s1_nxt.sol  = pitch + 4'd1;
            s1_nxt.fire = 1'b1;
          end else if (band == MENU_BAND) begin
            unique case (pitch)
              4'd0:    s1_nxt.act = ACT_MENU;
              4'd2:    s1_nxt.act = ACT_PREV;
              4'd4:    s1_nxt.act = ACT_NEXT;
              4'd5:    s1_nxt.act = ACT_DEC;
              4'd7:    s1_nxt.act = ACT_INC;
              default: s1_nxt.act = ACT_NONE;
            endcase
          end
        end
        OP_NOTE_OFF: begin
          if (pitch <= MAX_SOL_PITCH) begin
            s1_nxt.act = ACT_RELEASE;
            s1_nxt.sol = pitch + 4'd1;
          end
        end
        OP_CTRL_CHG: begin
          if (ev_key == STEPPER_CC) begin
            s1_nxt.act       = ACT_STEPPER;
            s1_nxt.raw_drive = ev_val;
          end
        end
        default: s1_nxt.act = ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) s1_r <= s1_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 2: offset times slope, kept as sign and magnitude.
  // --------------------------------------------------------------------------
  logic signed [15:0] prod;
  logic        [15:0] prod_abs;
  s2_t                s2_nxt, s2_r;

  assign prod     = $signed({1'b0, s1_r.xoff}) * s1_r.slope;
  assign prod_abs = prod[15] ? 16'(-prod) : prod;

  always_comb begin
    s2_nxt           = '0;
    s2_nxt.act       = s1_r.act;
    s2_nxt.sol       = s1_r.sol;
    s2_nxt.fire      = s1_r.fire;
    s2_nxt.raw_drive = s1_r.raw_drive;
    s2_nxt.neg       = prod[15];
    s2_nxt.mag       = prod_abs[13:0];
    s2_nxt.base      = s1_r.base;
  end

  always_ff @(posedge clk) begin
    if (ld2) s2_r <= s2_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitude divided by 63 through a reciprocal multiply.
  // --------------------------------------------------------------------------
  logic [28:0] recip_prod;
  s3_t         s3_nxt, s3_r;

  assign recip_prod = {15'd0, s2_r.mag} * {14'd0, DIV63_MUL};

  always_comb begin
    s3_nxt           = '0;
    s3_nxt.act       = s2_r.act;
    s3_nxt.sol       = s2_r.sol;
    s3_nxt.fire      = s2_r.fire;
    s3_nxt.raw_drive = s2_r.raw_drive;
    s3_nxt.neg       = s2_r.neg;
    s3_nxt.quo       = recip_prod[DIV63_SHIFT +: 8];
    s3_nxt.base      = s2_r.base;
  end

  always_ff @(posedge clk) begin
    if (ld3) s3_r <= s3_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 4: for a fire, apply the sign (truncation toward zero) and add the
  // segment base, else pass the controller value; load the output register.
  // --------------------------------------------------------------------------
  logic signed [9:0] quo_s;
  logic signed [9:0] shaped;
  logic        [7:0] drive_nxt;
  logic        [7:0] drive_r;
  logic        [3:0] sol_r;
  act_t              act_r;

  assign quo_s  = s3_r.neg ? -$signed({2'b00, s3_r.quo}) : $signed({2'b00, s3_r.quo});
  assign shaped = $signed({3'b000, s3_r.base}) + quo_s;

  always_comb begin
    if (s3_r.fire) begin
      drive_nxt = shaped[7:0];
    end else begin
      drive_nxt = {1'b0, s3_r.raw_drive};
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      act_r   <= s3_r.act;
      sol_r   <= s3_r.sol;
      drive_r <= drive_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tuser  = act_r;
  assign out_tdata  = {4'd0, drive_r, sol_r};

endmodule

@@ rtl/meadisp_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI actuator dispatch port checker
// Watches the top level ports for result consistency over time.
// ----------------------------------------------------------------------------
module meadisp_chk
  import meadisp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser
);

  logic [3:0] sol;
  logic [7:0] drive;

  assign sol   = out_tdata[3:0];
  assign drive = out_tdata[11:4];

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Fire and release name a solenoid from 1 to 8, every other action none.
  a_sol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ACT_FIRE || out_tuser == ACT_RELEASE)
                    ? (sol != 4'd0 && sol <= 4'd8) : (sol == 4'd0)))
    else $error("solenoid index does not match action");

  // Drive is zero unless the action is fire or stepper.
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ACT_FIRE && out_tuser != ACT_STEPPER |-> drive == 8'd0)
    else $error("drive set for an action that does not use it");

  // The stepper value is a plain controller value, never negative.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_STEPPER |-> !drive[7])
    else $error("negative stepper value");

  // The pipeline comes out of reset empty.
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind midi_event_actuator_dispatch_top meadisp_chk u_meadisp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event actuator dispatch testbench
// Self-checking stream test of the dispatcher against a behavioral predictor.
// ----------------------------------------------------------------------------
// A short table of directed events comes first. It covers the field extremes,
// every event kind, the fire and menu octaves, foreign channels and the
// unused event kind. The table runs with the reset register values. Then
// several register settings follow, each with a block of random events. The
// settings include the saturating channel write and the velocity curve
// extremes, one of which drives the shaped velocity down to -1. Every
// accepted request queues its expected action: typed rows from the table, the
// rest predicted on the spot. Each returned action is compared field by field
// with the oldest queued one. Both stream sides idle for a random number of
// cycles per request, with quiet stretches that have no idling at all.
// ----------------------------------------------------------------------------
module tb;
  import meadisp_pkg::*;

  // Event kind 3 has no meaning; the block must answer it with no action.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Key bands (key / 12) that hold the solenoid and menu notes.
  localparam int FIRE_KEY_BAND = 6;
  localparam int MENU_KEY_BAND = 3;
  localparam int TOP_SOL_PITCH = 7;

  localparam int RANDOM_EVENTS_PER_SETTING = 95;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    act_t              act;
    logic [3:0]        sol;
    logic signed [7:0] drive;
  } dispatch_t;

  typedef struct {
    logic [1:0] op;
    logic [4:0] chan;
    logic [6:0] key;
    logic [6:0] val;
    bit         typed;
    dispatch_t  want;
  } event_row_t;

  typedef struct {
    logic [4:0] chan;
    logic [6:0] floor_v;
    logic [6:0] ceil_v;
    logic [6:0] knee_v;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n;

  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // event_channel[4:0], key_number[11:5],
                           // event_value[18:12], zero pad[23:19]
  logic [1:0]  in_tuser;   // operation[1:0]

  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // solenoid_index[3:0], drive_amount[11:4],
                           // zero pad[15:12]
  logic [3:0]  out_tuser;  // action[3:0]

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the dispatcher registers, kept in step with every write.
  logic [4:0] listen_ch;
  int         vel_floor;
  int         vel_ceil;
  int         vel_knee;

  dispatch_t expected_actions[$];

  int mismatch_count = 0;
  int actions_checked = 0;
  int events_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  // When set, the matching side runs back to back with no idle cycles.
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;

  midi_event_actuator_dispatch_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d actions still pending",
               cycle_count, expected_actions.size());
      $display("simulation failed");
      $finish;
    end
  end

  // The velocity curve has two straight segments that meet at the knee.
  // SystemVerilog int division truncates toward zero, as the block does.
  function automatic logic signed [7:0] shape_velocity(input logic [6:0] raw);
    int x;
    int shaped;
    x = raw;
    if (x < 64) begin
      shaped = vel_floor + (x * (vel_knee - 1 - vel_floor)) / 63;
    end else begin
      shaped = vel_knee + ((x - 64) * (vel_ceil - vel_knee)) / 63;
    end
    return shaped[7:0];
  endfunction

  function automatic dispatch_t dispatch_event(input logic [1:0] op,
                                               input logic [4:0] chan,
                                               input logic [6:0] key,
                                               input logic [6:0] val);
    dispatch_t r;
    int pitch;
    int band;
    r = '{act: ACT_NONE, sol: 4'd0, drive: 8'sd0};
    pitch = key % 12;
    band = key / 12;
    if (chan == listen_ch) begin
      case (op)
        OP_NOTE_ON: begin
          if (band == FIRE_KEY_BAND && pitch <= TOP_SOL_PITCH) begin
            r.act = ACT_FIRE;
            r.sol = 4'(pitch + 1);
            r.drive = shape_velocity(val);
          end else if (band == MENU_KEY_BAND) begin
            case (pitch)
              0: r.act = ACT_MENU;
              2: r.act = ACT_PREV;
              4: r.act = ACT_NEXT;
              5: r.act = ACT_DEC;
              7: r.act = ACT_INC;
              default: r.act = ACT_NONE;
            endcase
          end
        end
        OP_NOTE_OFF: begin
          if (pitch <= TOP_SOL_PITCH) begin
            r.act = ACT_RELEASE;
            r.sol = 4'(pitch + 1);
          end
        end
        OP_CTRL_CHG: begin
          if (key == STEPPER_CC) begin
            r.act = ACT_STEPPER;
            r.drive = $signed({1'b0, val});
          end
        end
        default: r.act = ACT_NONE;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sends one event request; the expected action is queued once it is taken.
  task automatic send_event(input logic [1:0] op, input logic [4:0] chan,
                            input logic [6:0] key, input logic [6:0] val,
                            input bit typed, input dispatch_t typed_want);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, val, key, chan};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    expected_actions.push_back(typed ? typed_want : dispatch_event(op, chan, key, val));
    events_sent++;
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
  endtask

  // Releases the input and waits until every queued action has come back.
  task automatic drain_actions();
    in_tvalid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
  endtask

  // The bus goes idle after each write, so back-to-back writes never drive the
  // select twice in the same edge.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (index)
      REG_LISTEN_CH: listen_ch = (value[4:0] > LISTEN_CH_MAX) ? LISTEN_CH_MAX : value[4:0];
      REG_VEL_FLOOR: vel_floor = value[6:0];
      REG_VEL_CEIL:  vel_ceil = value[6:0];
      REG_VEL_KNEE:  vel_knee = value[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_register(REG_LISTEN_CH, 32'(s.chan));
    write_register(REG_VEL_FLOOR, 32'(s.floor_v));
    write_register(REG_VEL_CEIL, 32'(s.ceil_v));
    write_register(REG_VEL_KNEE, 32'(s.knee_v));
    settings_used++;
  endtask

  // Random events lean toward the listening channel and the mapped keys so
  // that most requests produce a real action; the rest is noise.
  task automatic send_random_events(input int count);
    logic [1:0] op;
    logic [4:0] chan;
    logic [6:0] key;
    logic [6:0] val;
    int pick;
    for (int n = 0; n < count; n++) begin
      chan = ($urandom_range(0, 3) != 0) ? listen_ch : 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        op = OP_NOTE_ON;
      end else if (pick <= 6) begin
        op = OP_NOTE_OFF;
      end else if (pick <= 8) begin
        op = OP_CTRL_CHG;
      end else begin
        op = OP_UNUSED;
      end
      pick = $urandom_range(0, 3);
      if (op == OP_CTRL_CHG) begin
        key = (pick != 0) ? STEPPER_CC : 7'($urandom_range(0, 127));
      end else if (op == OP_NOTE_ON && pick <= 1) begin
        key = 7'($urandom_range(72, 83));
      end else if (op == OP_NOTE_ON && pick == 2) begin
        key = 7'($urandom_range(36, 47));
      end else begin
        key = 7'($urandom_range(0, 127));
      end
      // The segment ends of the curve are worth hitting more often.
      case ($urandom_range(0, 7))
        0: val = 7'd0;
        1: val = 7'd63;
        2: val = 7'd64;
        3: val = 7'd127;
        default: val = 7'($urandom_range(0, 127));
      endcase
      send_event(op, chan, key, val, 1'b0, '0);
    end
  endtask

  // The result side stalls for a random number of cycles before each action.
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
    end
  end

  // Every accepted action is checked against the oldest expectation.
  always @(posedge clk) begin : action_check
    dispatch_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch("unexpected action", out_tuser, -1);
      end else begin
        want = expected_actions.pop_front();
        actions_checked++;
        if (out_tuser !== want.act) begin
          report_mismatch("action", out_tuser, want.act);
        end
        if (out_tdata[3:0] !== want.sol) begin
          report_mismatch("solenoid_index", out_tdata[3:0], want.sol);
        end
        if (out_tdata[11:4] !== want.drive) begin
          report_mismatch("drive_amount", $signed(out_tdata[11:4]), want.drive);
        end
        if (out_tdata[15:12] !== 4'd0) begin
          report_mismatch("out_tdata pad", out_tdata[15:12], 0);
        end
      end
    end
  end

  initial begin : stimulus
    event_row_t directed_rows [25];
    setting_t settings [5];

    // Typed expectations come straight from the reset curve:
    // floor 0, knee 64, ceiling 127, listening channel 1.
    directed_rows = '{
      '{OP_NOTE_ON,  5'd1,  7'd72,  7'd0,   1'b1, '{ACT_FIRE, 4'd1, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd79,  7'd127, 1'b1, '{ACT_FIRE, 4'd8, 8'sd127}},
      '{OP_NOTE_ON,  5'd1,  7'd72,  7'd63,  1'b1, '{ACT_FIRE, 4'd1, 8'sd63}},
      '{OP_NOTE_ON,  5'd1,  7'd77,  7'd64,  1'b1, '{ACT_FIRE, 4'd6, 8'sd64}},
      '{OP_NOTE_ON,  5'd1,  7'd80,  7'd100, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd36,  7'd50,  1'b1, '{ACT_MENU, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd38,  7'd50,  1'b1, '{ACT_PREV, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd40,  7'd50,  1'b1, '{ACT_NEXT, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd41,  7'd50,  1'b1, '{ACT_DEC, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd43,  7'd50,  1'b1, '{ACT_INC, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd37,  7'd50,  1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd0,   7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd127, 7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_OFF, 5'd1,  7'd0,   7'd127, 1'b1, '{ACT_RELEASE, 4'd1, 8'sd0}},
      '{OP_NOTE_OFF, 5'd1,  7'd127, 7'd0,   1'b1, '{ACT_RELEASE, 4'd8, 8'sd0}},
      '{OP_NOTE_OFF, 5'd1,  7'd11,  7'd9,   1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_CTRL_CHG, 5'd1,  7'd22,  7'd127, 1'b1, '{ACT_STEPPER, 4'd0, 8'sd127}},
      '{OP_CTRL_CHG, 5'd1,  7'd22,  7'd0,   1'b1, '{ACT_STEPPER, 4'd0, 8'sd0}},
      '{OP_CTRL_CHG, 5'd1,  7'd23,  7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_UNUSED,   5'd1,  7'd72,  7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd0,  7'd72,  7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd31, 7'd72,  7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd16, 7'd72,  7'd127, 1'b1, '{ACT_NONE, 4'd0, 8'sd0}},
      '{OP_NOTE_ON,  5'd1,  7'd75,  7'd100, 1'b0, '0},
      '{OP_NOTE_ON,  5'd1,  7'd83,  7'd1,   1'b0, '0}
    };

    // Channel 31 must saturate to 16. A knee of zero with a zero floor drives
    // the low segment to -1, and a high floor over a low ceiling makes the
    // curve fall instead of rise.
    settings = '{
      '{5'd31, 7'd0,   7'd0,   7'd0},
      '{5'd0,  7'd127, 7'd127, 7'd127},
      '{5'd16, 7'd127, 7'd0,   7'd0},
      '{5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
        7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))},
      '{5'd1,  7'd10,  7'd120, 7'd90}
    };

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_NOTE_ON;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;

    listen_ch = LISTEN_CH_RESET;
    vel_floor = VEL_FLOOR_RESET;
    vel_ceil = VEL_CEIL_RESET;
    vel_knee = VEL_KNEE_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].op, directed_rows[i].chan, directed_rows[i].key,
                 directed_rows[i].val, directed_rows[i].typed, directed_rows[i].want);
    end

    // Registers change only once the pipeline has emptied.
    foreach (settings[i]) begin
      drain_actions();
      apply_setting(settings[i]);
      send_random_events(RANDOM_EVENTS_PER_SETTING);
    end

    drain_actions();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_actions.size() != 0) begin
      report_mismatch("actions never returned", 0, expected_actions.size());
    end

    $display("%0d events dispatched under the reset curve and %0d register settings",
             events_sent, settings_used);
    $display("%0d actions compared, %0d mismatches", actions_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
